>>> src/clc_pkg.sv
// shared types and constants for the content line counter
package clc_pkg;

  // width of the running line total
  localparam int COUNT_WIDTH = 32;
  // width of one text byte and of the reported count
  localparam int BYTE_W    = 8;
  localparam int CONTENT_W = 32;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  // characters the scanner reacts to
  localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
  localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [BYTE_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;

  // scanner modes
  typedef enum logic [2:0] {
    MODE_LINE_START        = 3'd0,
    MODE_AFTER_TOP_COMMENT = 3'd1,
    MODE_CONTENT           = 3'd2,
    MODE_SKIP_LINE         = 3'd3,
    MODE_TOP_COMMENT       = 3'd4,
    MODE_CONTENT_COMMENT   = 3'd5,
    MODE_DRAIN             = 3'd6
  } mode_t;

  // scanner state carried from one byte to the next
  typedef struct packed {
    mode_t mode;
    logic  star_before;
    logic  comment_crossed_line;
  } scan_st_t;

  localparam scan_st_t SCAN_CLEAR = '{
    mode: MODE_LINE_START,
    star_before: 1'b0,
    comment_crossed_line: 1'b0
  };

endpackage

>>> src/clc_step.sv
// one scanner step: a byte and its lookahead update the mode
module clc_step
  import clc_pkg::*;
(
  input  scan_st_t          st_i,
  input  logic [BYTE_W-1:0] c0_i,
  input  logic [BYTE_W-1:0] c1_i,
  output scan_st_t          st_o,
  output logic              inc_o
);

  logic     c0_slash;
  logic     open_pair;
  logic     crlf;
  scan_st_t content_st;

  assign c0_slash  = (c0_i == CH_SLASH);
  assign open_pair = c0_slash && (c1_i == CH_STAR);
  assign crlf      = (c0_i == CH_CR) && (c1_i == CH_LF);

  // follow-on state for a byte that is content
  always_comb begin
    content_st = st_i;
    if (c0_i == CH_LF) begin
      content_st.mode = MODE_LINE_START;
    end else if (open_pair) begin
      content_st.mode                 = MODE_CONTENT_COMMENT;
      content_st.star_before          = 1'b0;
      content_st.comment_crossed_line = 1'b0;
    end else begin
      content_st.mode = MODE_CONTENT;
    end
  end

  // mode transitions
  always_comb begin
    st_o  = st_i;
    inc_o = 1'b0;
    unique case (st_i.mode)
      MODE_LINE_START: begin
        if (c0_slash && (c1_i == CH_SLASH)) begin
          st_o.mode = MODE_SKIP_LINE;
        end else if (open_pair) begin
          st_o.mode        = MODE_TOP_COMMENT;
          st_o.star_before = 1'b0;
        end else if (c0_i == CH_LF) begin
          st_o.mode = MODE_LINE_START;
        end else if (crlf) begin
          st_o.mode = MODE_SKIP_LINE;
        end else begin
          inc_o = 1'b1;
          st_o  = content_st;
        end
      end
      MODE_AFTER_TOP_COMMENT: begin
        if (c0_i == CH_LF) begin
          st_o.mode = MODE_LINE_START;
        end else if (crlf) begin
          st_o.mode = MODE_SKIP_LINE;
        end else begin
          inc_o = 1'b1;
          st_o  = content_st;
        end
      end
      MODE_CONTENT: begin
        st_o = content_st;
      end
      MODE_SKIP_LINE: begin
        if (c0_i == CH_LF) begin
          st_o.mode = MODE_LINE_START;
        end
      end
      MODE_TOP_COMMENT, MODE_CONTENT_COMMENT: begin
        if (st_i.star_before && c0_slash) begin
          st_o.star_before = 1'b0;
          if (st_i.mode == MODE_TOP_COMMENT) begin
            st_o.mode = MODE_AFTER_TOP_COMMENT;
          end else if (st_i.comment_crossed_line) begin
            st_o.mode = MODE_LINE_START;
          end else begin
            st_o.mode = MODE_SKIP_LINE;
          end
        end else begin
          st_o.star_before = (c0_i == CH_STAR);
          if (c0_i == CH_LF) begin
            st_o.comment_crossed_line = 1'b1;
          end
        end
      end
      default: begin
        st_o.mode = MODE_LINE_START;
      end
    endcase
  end

endmodule

>>> src/clc_scan.sv
// scanner state, lookahead byte and saturating line total
module clc_scan
  import clc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en_i,
  input  logic [BYTE_W-1:0]    byte_i,
  input  logic                 fin_i,
  output logic                 res_valid_o,
  output logic [CONTENT_W-1:0] res_count_o
);

  scan_st_t               st_r, st_nxt;
  logic [BYTE_W-1:0]      held_byte_r, held_byte_nxt;
  logic                   held_valid_r, held_valid_nxt;
  logic [COUNT_WIDTH-1:0] line_total_r, line_total_nxt;

  scan_st_t               st_step_a, st_a, st_b;
  logic                   inc_step_a, inc_a, inc_b, use_b;
  logic                   byte_nz, is_drain;
  logic [COUNT_WIDTH:0]   sum;
  logic [COUNT_WIDTH-1:0] total_sat;

  assign byte_nz  = (byte_i != CH_NUL);
  assign is_drain = (st_r.mode == MODE_DRAIN);

  // held byte processed with the new byte as lookahead
  clc_step u_step_a (
    .st_i  (st_r),
    .c0_i  (held_byte_r),
    .c1_i  (byte_i),
    .st_o  (st_step_a),
    .inc_o (inc_step_a)
  );

  assign st_a  = held_valid_r ? st_step_a : st_r;
  assign inc_a = held_valid_r && inc_step_a;

  // a final nonzero byte is processed at once with zero lookahead
  clc_step u_step_b (
    .st_i  (st_a),
    .c0_i  (byte_i),
    .c1_i  (CH_NUL),
    .st_o  (st_b),
    .inc_o (inc_b)
  );

  assign use_b = byte_nz && fin_i;

  // saturating total
  assign sum = {1'b0, line_total_r} + {{COUNT_WIDTH{1'b0}}, inc_a}
             + {{COUNT_WIDTH{1'b0}}, use_b && inc_b};
  assign total_sat = sum[COUNT_WIDTH] ? COUNT_MAX : sum[COUNT_WIDTH-1:0];

  assign res_valid_o = !is_drain && (!byte_nz || fin_i);
  assign res_count_o = CONTENT_W'(total_sat);

  // next state
  always_comb begin
    st_nxt         = st_r;
    held_byte_nxt  = held_byte_r;
    held_valid_nxt = held_valid_r;
    line_total_nxt = line_total_r;
    if (en_i) begin
      if (is_drain) begin
        if (fin_i) begin
          st_nxt = SCAN_CLEAR;
        end
      end else if (res_valid_o) begin
        st_nxt         = SCAN_CLEAR;
        held_byte_nxt  = CH_NUL;
        held_valid_nxt = 1'b0;
        line_total_nxt = '0;
        if (!byte_nz && !fin_i) begin
          st_nxt.mode = MODE_DRAIN;
        end
      end else begin
        st_nxt         = st_a;
        held_byte_nxt  = byte_i;
        held_valid_nxt = 1'b1;
        line_total_nxt = total_sat;
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= SCAN_CLEAR;
      held_byte_r  <= CH_NUL;
      held_valid_r <= 1'b0;
      line_total_r <= '0;
    end else begin
      st_r         <= st_nxt;
      held_byte_r  <= held_byte_nxt;
      held_valid_r <= held_valid_nxt;
      line_total_r <= line_total_nxt;
    end
  end

endmodule

>>> src/code_line_counter.sv
// content line counter: input register, scanner and result register
// Path: an accepted request waits in the input register and is scanned when
//   the stage advances; a count it ends appears on out_tvalid from the result register.
// Throughput: one byte per cycle through the scanner between the input
//   register and the result register; stalls only while a count waits.
// Reset: synchronous, active low; clears the valid flags of both registers,
//   the scanner mode, the lookahead byte and the line total.
module code_line_counter
  import clc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [BYTE_W-1:0]    in_tdata,   // [7:0] text_byte
  input  logic                 in_tlast,   // final_byte
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [CONTENT_W-1:0] out_tdata   // [31:0] content_lines
);

  logic                 in_valid_r, in_valid_nxt;
  logic [BYTE_W-1:0]    in_data_r, in_data_nxt;
  logic                 in_last_r, in_last_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [CONTENT_W-1:0] out_data_r, out_data_nxt;

  logic                 adv, fire;
  logic                 res_valid;
  logic [CONTENT_W-1:0] res_count;

  // stage moves whenever the result register is free or being drained
  assign adv       = !out_valid_r || out_tready;
  assign fire      = in_valid_r && adv;
  assign in_tready = !in_valid_r || adv;

  clc_scan u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .en_i        (fire),
    .byte_i      (in_data_r),
    .fin_i       (in_last_r),
    .res_valid_o (res_valid),
    .res_count_o (res_count)
  );

  // input and result register next values
  always_comb begin
    in_valid_nxt  = in_valid_r;
    in_data_nxt   = in_data_r;
    in_last_nxt   = in_last_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (in_tvalid && in_tready) begin
      in_valid_nxt = 1'b1;
      in_data_nxt  = in_tdata;
      in_last_nxt  = in_tlast;
    end else if (fire) begin
      in_valid_nxt = 1'b0;
    end
    if (adv) begin
      out_valid_nxt = fire && res_valid;
      out_data_nxt  = res_count;
    end
  end

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_data_r  <= in_data_nxt;
    in_last_r  <= in_last_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

>>> src/clc_checker.sv
// port-level checks for the content line counter, bound to the top level
module clc_port_checks
  import clc_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_tready,
  input logic                 out_tvalid,
  input logic                 out_tready,
  input logic [CONTENT_W-1:0] out_tdata
);

  // a stalled count holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("count changed while stalled");

  // input only backs up behind a waiting count
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without a waiting count");

  // a draining output never blocks the input
  a_in_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input blocked while output drains");

  // no count straight out of reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("count shown straight after reset");

endmodule

bind code_line_counter clc_port_checks u_clc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
